// ===== rtl/core/hsda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsda_pkg
// types, constants and the hall pattern decode shared by the sector decoder
// ----------------------------------------------------------------------------
package hsda_pkg;

    localparam int SECTOR_W = 3;
    localparam int ANGLE_W  = 13;
    localparam int DIR_W    = 4;
    localparam int CNT_W    = 4;
    localparam int SUM_W    = ANGLE_W + 1;

    typedef logic [SECTOR_W-1:0]       sector_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [DIR_W-1:0]   dir_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    localparam cnt_t   CONFIRM_RESET  = 4'd3;
    localparam cnt_t   CNT_MAX        = 4'd15;
    localparam sum_t   ANGLE_STEP     = 14'sd75;
    localparam sum_t   ANGLE_FULL     = 14'sd3600;
    localparam angle_t ANGLE_ERR_LOW  = -13'sd1;
    localparam angle_t ANGLE_ERR_JUMP = -13'sd2;
    localparam dir_t   DIR_WRAP_LO    = -4'sd5;
    localparam dir_t   DIR_WRAP_HI    = 4'sd5;
    localparam dir_t   DIR_SECTORS    = 4'sd6;
    localparam dir_t   DIR_JUMP       = 4'sd2;

    // register indexes on the apb port (byte address bit 2)
    localparam logic REG_CONFIRM_COUNT = 1'b0;

    // hall line patterns {a, b, c}
    localparam logic [2:0] PAT_ALL_LOW = 3'b000;

    typedef struct packed {
        logic    ok;
        sector_t sector;
    } sector_dec_t;

    function automatic sector_dec_t decode_pattern(input logic [2:0] pat);
        sector_dec_t d;
        d.ok = 1'b1;
        case (pat)
            3'b001:  d.sector = 3'd5;
            3'b101:  d.sector = 3'd4;
            3'b100:  d.sector = 3'd3;
            3'b110:  d.sector = 3'd2;
            3'b010:  d.sector = 3'd1;
            3'b011:  d.sector = 3'd0;
            default:
            begin
                d.ok     = 1'b0;
                d.sector = 3'd0;
            end
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/hsda_hall_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsda_hall_if
// valid/ready channel carrying one sample of the three hall lines
// ----------------------------------------------------------------------------
interface hsda_hall_if;
    logic valid;
    logic ready;
    logic hall_a;
    logic hall_b;
    logic hall_c;

    modport source (output valid, output hall_a, output hall_b, output hall_c, input ready);
    modport sink   (input valid, input hall_a, input hall_b, input hall_c, output ready);
    modport monitor (input valid, input ready, input hall_a, input hall_b, input hall_c);
endinterface

// ===== rtl/core/hsda_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsda_result_if
// valid/ready channel carrying angle, direction step and debounced sector
// ----------------------------------------------------------------------------
interface hsda_result_if;
    logic             valid;
    logic             ready;
    hsda_pkg::angle_t  rotor_angle;
    hsda_pkg::dir_t    step_direction;
    hsda_pkg::sector_t accepted_sector;

    modport source (output valid, output rotor_angle, output step_direction,
                    output accepted_sector, input ready);
    modport sink   (input valid, input rotor_angle, input step_direction,
                    input accepted_sector, output ready);
    modport monitor (input valid, input ready, input rotor_angle, input step_direction,
                     input accepted_sector);
endinterface

// ===== rtl/core/hall_sector_debounce_and_angle_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_sector_debounce_and_angle_top
// hall sector decode, debounce and rotor angle tracking
// ----------------------------------------------------------------------------
// channel   dir  handshake      beat contents
// hall      in   valid/ready    hall_a, hall_b, hall_c
// result    out  valid/ready    rotor_angle, step_direction, accepted_sector
// apb       in   psel/penable   confirm_count at byte address 0
//
// one hall beat accepted per clock while hall.ready is high; each beat passes
// the input register, then the result register, one result beat per hall beat
// state update and result are computed combinationally from the input register
// rst_n clears control and most tracking state and loads confirm_count with 3
// a stalled result holds in the result register while the input register
// still takes one more beat; hall.ready drops only when both are full
// ----------------------------------------------------------------------------
module hall_sector_debounce_and_angle_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    hsda_hall_if.sink            hall,
    hsda_result_if.source        result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    hsda_pkg::cnt_t confirm_reg;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == hsda_pkg::REG_CONFIRM_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_reg <= hsda_pkg::CONFIRM_RESET;
        end
        else if (cfg_wr)
        begin
            confirm_reg <= pwdata[hsda_pkg::CNT_W-1:0];
        end
    end

    // other word addresses read as zero
    assign prdata = (paddr[2] == hsda_pkg::REG_CONFIRM_COUNT)
                    ? {{(32-hsda_pkg::CNT_W){1'b0}}, confirm_reg} : 32'd0;

    // ------------------------------------------------------------------
    // pipeline control: input register -> result register
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [2:0] pat_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       in_take;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign hall.ready = !in_valid_reg || advance;
    assign in_take    = hall.valid && hall.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pattern register carries no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pat_reg <= {hall.hall_a, hall.hall_b, hall.hall_c};
        end
    end

    // ------------------------------------------------------------------
    // tracking state
    // ------------------------------------------------------------------
    hsda_pkg::sector_t raw_reg;
    hsda_pkg::sector_t prev_reg;
    hsda_pkg::cnt_t    cnt_reg;
    hsda_pkg::sector_t cur_reg;
    hsda_pkg::sector_t ref_reg;
    logic              seeded_reg;
    hsda_pkg::angle_t  acc_reg;

    hsda_pkg::sector_dec_t dec;
    hsda_pkg::sector_t raw_next;
    hsda_pkg::sector_t cur_seed;
    hsda_pkg::sector_t ref_seed;
    hsda_pkg::cnt_t    cnt_inc;
    hsda_pkg::cnt_t    cnt_next;
    hsda_pkg::sector_t cur_next;
    logic              repeat_hit;
    hsda_pkg::dir_t    diff;
    hsda_pkg::dir_t    dir;
    hsda_pkg::sum_t    step;
    hsda_pkg::sum_t    sum;
    hsda_pkg::sum_t    sum_wrapped;
    hsda_pkg::angle_t  acc_next;

    always_comb
    begin
        dec      = hsda_pkg::decode_pattern(pat_reg);
        // invalid patterns (all low, all high) keep the last raw sector
        raw_next = dec.ok ? dec.sector : raw_reg;

        // first sample seeds current and reference
        cur_seed = seeded_reg ? cur_reg : raw_next;
        ref_seed = seeded_reg ? ref_reg : raw_next;

        // debounce: a differing sector must repeat confirm_count times
        repeat_hit = (raw_next != ref_seed) && (raw_next == prev_reg);
        cnt_inc    = (cnt_reg != hsda_pkg::CNT_MAX) ? cnt_reg + 4'd1 : cnt_reg;
        cnt_next   = '0;
        cur_next   = cur_seed;
        if (repeat_hit)
        begin
            if (cnt_inc >= confirm_reg)
            begin
                cur_next = raw_next;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end

        // sector difference wrapped into -4..4
        diff = $signed({1'b0, cur_next}) - $signed({1'b0, ref_seed});
        if (diff <= hsda_pkg::DIR_WRAP_LO)
        begin
            dir = diff + hsda_pkg::DIR_SECTORS;
        end
        else if (diff >= hsda_pkg::DIR_WRAP_HI)
        begin
            dir = diff - hsda_pkg::DIR_SECTORS;
        end
        else
        begin
            dir = diff;
        end

        // angle moves 75 per step, wrapped into 0..3599
        step = hsda_pkg::sum_t'(dir) * hsda_pkg::ANGLE_STEP;
        sum  = hsda_pkg::sum_t'(acc_reg) + step;
        if (sum >= hsda_pkg::ANGLE_FULL)
        begin
            sum_wrapped = sum - hsda_pkg::ANGLE_FULL;
        end
        else if (sum < 0)
        begin
            sum_wrapped = sum + hsda_pkg::ANGLE_FULL;
        end
        else
        begin
            sum_wrapped = sum;
        end

        // no step keeps the accumulator as is, error codes included
        acc_next = (dir != '0) ? sum_wrapped[hsda_pkg::ANGLE_W-1:0] : acc_reg;
        if (pat_reg == hsda_pkg::PAT_ALL_LOW)
        begin
            acc_next = hsda_pkg::ANGLE_ERR_LOW;
        end
        // a jump of two sectors or more overrides the all-low code
        if ((dir >= hsda_pkg::DIR_JUMP) || (dir <= -hsda_pkg::DIR_JUMP))
        begin
            acc_next = hsda_pkg::ANGLE_ERR_JUMP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg    <= '0;
            prev_reg   <= '0;
            cnt_reg    <= '0;
            seeded_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else if (advance)
        begin
            raw_reg    <= raw_next;
            prev_reg   <= raw_next;
            cnt_reg    <= cnt_next;
            seeded_reg <= 1'b1;
            acc_reg    <= acc_next;
        end
    end

    // sectors are seeded by the first sample, no reset needed
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cur_reg <= cur_next;
            ref_reg <= cur_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    hsda_pkg::angle_t  angle_out_reg;
    hsda_pkg::dir_t    dir_out_reg;
    hsda_pkg::sector_t sector_out_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            angle_out_reg  <= acc_next;
            dir_out_reg    <= dir;
            sector_out_reg <= cur_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.rotor_angle     = angle_out_reg;
    assign result.step_direction  = dir_out_reg;
    assign result.accepted_sector = sector_out_reg;

endmodule

// ===== rtl/core/hsda_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsda_checker
// port-level checks on the result channel of the hall sector decoder
// ----------------------------------------------------------------------------
module hsda_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input hsda_pkg::angle_t  res_angle,
    input hsda_pkg::dir_t    res_step,
    input hsda_pkg::sector_t res_sector
);

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_angle)
            && $stable(res_step) && $stable(res_sector)))
        else $error("result beat changed while stalled");

    a_sector: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_sector <= 3'd5))
        else $error("accepted sector out of range");

    a_angle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_angle >= -13'sd2) && (res_angle <= 13'sd3599)))
        else $error("rotor angle out of range");

    a_dir: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_step >= -4'sd4) && (res_step <= 4'sd4)))
        else $error("step direction out of range");

    // a jump always reports the jump code
    a_jump: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && ((res_step >= 4'sd2) || (res_step <= -4'sd2)))
            |-> (res_angle == -13'sd2))
        else $error("sector jump without jump code");

endmodule

bind hall_sector_debounce_and_angle_top hsda_checker u_hsda_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_angle  (result.rotor_angle),
    .res_step   (result.step_direction),
    .res_sector (result.accepted_sector)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hall sector debouncer and rotor angle tracker
// ----------------------------------------------------------------------------
// hall samples go in on a valid/ready channel; every accepted sample runs
// through a behavioral sector tracker that predicts its result beat, and the
// result channel is compared field by field against the oldest prediction.
// a short table of hand-picked samples comes first, then random rotation
// traffic in six phases, each with its own confirm_count written over apb
// while the block is empty, and with changing idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF_NS  = 6;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SEG_ITEMS    = 125;
    localparam int NUM_SEGS     = 6;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 20;
    localparam int NUM_DIRECTED = 25;
    localparam int NUM_SECTORS  = 6;
    localparam int DEG_PER_STEP = 75;
    localparam int FULL_TURN    = 3600;

    // byte address of the only register
    localparam logic [2:0] ADDR_CONFIRM = {hsda_pkg::REG_CONFIRM_COUNT, 2'b00};
    localparam logic [2:0] PAT_ALL_HIGH = 3'b111;

    // {a, b, c} line pattern for each sector
    localparam logic [2:0] SECTOR_PAT [NUM_SECTORS] =
        '{3'b011, 3'b010, 3'b110, 3'b100, 3'b101, 3'b001};

    typedef struct packed {
        hsda_pkg::angle_t  angle;
        hsda_pkg::dir_t    step;
        hsda_pkg::sector_t sector;
    } angle_beat_t;

    typedef struct packed {
        logic [2:0]  pat;
        logic        typed;
        angle_beat_t want;
    } hall_row_t;

    // hand-picked opening run at the reset confirm_count of 3; rows with
    // typed set carry a result that is obvious from the sequence
    localparam hall_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // first sample all high: seeds sector 0
        '{PAT_ALL_HIGH, 1'b1, '{13'sd0, 4'sd0, 3'd0}},
        // all low: angle forced to the low-lines code
        '{hsda_pkg::PAT_ALL_LOW,  1'b1, '{hsda_pkg::ANGLE_ERR_LOW, 4'sd0, 3'd0}},
        // sector 5, confirmed by an all-low sample, wraps backwards
        '{3'b001, 1'b0, '0},
        '{3'b001, 1'b0, '0},
        '{3'b001, 1'b0, '0},
        '{hsda_pkg::PAT_ALL_LOW,  1'b0, '0},
        // back to sector 0, wraps forwards out of the error value
        '{3'b011, 1'b0, '0},
        '{3'b011, 1'b0, '0},
        '{3'b011, 1'b0, '0},
        '{3'b011, 1'b0, '0},
        // sector 1 with an all-high sample inside the run
        '{3'b010, 1'b0, '0},
        '{3'b010, 1'b0, '0},
        '{PAT_ALL_HIGH, 1'b0, '0},
        '{3'b010, 1'b0, '0},
        // glitch towards sector 2 that falls back before confirming
        '{3'b110, 1'b0, '0},
        '{3'b110, 1'b0, '0},
        '{3'b010, 1'b0, '0},
        // jump of three sectors
        '{3'b101, 1'b0, '0},
        '{3'b101, 1'b0, '0},
        '{3'b101, 1'b0, '0},
        '{3'b101, 1'b1, '{hsda_pkg::ANGLE_ERR_JUMP, 4'sd3, 3'd4}},
        // jump of minus four sectors
        '{3'b011, 1'b0, '0},
        '{3'b011, 1'b0, '0},
        '{3'b011, 1'b0, '0},
        '{3'b011, 1'b1, '{hsda_pkg::ANGLE_ERR_JUMP, -4'sd4, 3'd0}}
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hsda_hall_if   hall_ch ();
    hsda_result_if res_ch ();

    // predicted result beats, oldest first
    angle_beat_t angle_q [$];

    int fail_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;

    // behavioral copy of the tracking state
    hsda_pkg::sector_t trk_raw;
    hsda_pkg::sector_t trk_prev;
    hsda_pkg::sector_t trk_cur;
    hsda_pkg::sector_t trk_ref;
    hsda_pkg::cnt_t    trk_cnt;
    hsda_pkg::cnt_t    trk_confirm;
    logic              trk_seeded;
    int                trk_acc;

    hall_sector_debounce_and_angle_top u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .hall    (hall_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // advance the tracker by one hall sample and return the beat it yields
    function automatic angle_beat_t track_sample(input logic [2:0] pat);
        angle_beat_t r;
        int          step;
        // all-low and all-high match no sector and leave the raw sector alone
        for (int s = 0; s < NUM_SECTORS; s++)
            if (SECTOR_PAT[s] == pat)
                trk_raw = hsda_pkg::sector_t'(s);
        if (!trk_seeded)
        begin
            trk_cur    = trk_raw;
            trk_ref    = trk_raw;
            trk_seeded = 1'b1;
        end
        // debounce: count repeats of a raw sector that differs from the reference
        if (trk_raw != trk_ref && trk_raw == trk_prev)
        begin
            if (trk_cnt < hsda_pkg::CNT_MAX)
                trk_cnt = trk_cnt + 1'b1;
            if (trk_cnt >= trk_confirm)
            begin
                trk_cnt = '0;
                trk_cur = trk_raw;
            end
        end
        else
            trk_cnt = '0;
        trk_prev = trk_raw;
        step = int'(trk_cur) - int'(trk_ref);
        if (step != 0)
        begin
            // a difference of five sectors wraps round the six sectors, into -4..4
            if (step <= -5)
                step += NUM_SECTORS;
            else if (step >= 5)
                step -= NUM_SECTORS;
            trk_acc += DEG_PER_STEP * step;
            if (trk_acc >= FULL_TURN)
                trk_acc -= FULL_TURN;
            else if (trk_acc < 0)
                trk_acc += FULL_TURN;
            trk_ref = trk_cur;
        end
        // error codes land in the accumulator itself; a jump beats all-low
        if (pat == hsda_pkg::PAT_ALL_LOW)
            trk_acc = int'(hsda_pkg::ANGLE_ERR_LOW);
        if (step <= -2 || step >= 2)
            trk_acc = int'(hsda_pkg::ANGLE_ERR_JUMP);
        r.angle  = trk_acc[hsda_pkg::ANGLE_W-1:0];
        r.step   = step[hsda_pkg::DIR_W-1:0];
        r.sector = trk_cur;
        return r;
    endfunction

    // offer one hall beat, with random idle cycles ahead of it; valid stays
    // high afterwards so back-to-back beats need no extra assignment
    task automatic send_sample(input logic [2:0] pat, input logic typed,
                               input angle_beat_t want);
        angle_beat_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            hall_ch.valid <= 1'b0;
            @(posedge clk);
        end
        hall_ch.valid  <= 1'b1;
        hall_ch.hall_a <= pat[2];
        hall_ch.hall_b <= pat[1];
        hall_ch.hall_c <= pat[0];
        @(posedge clk);
        while (!hall_ch.ready)
            @(posedge clk);
        pred = track_sample(pat);
        angle_q.push_back(typed ? want : pred);
    endtask

    // stop offering and wait until every predicted beat has come out
    task automatic drain_results();
        int waited;
        waited = 0;
        hall_ch.valid <= 1'b0;
        @(posedge clk);
        while (angle_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (angle_q.size() != 0)
        begin
            $error("%0d predicted result beats never arrived", angle_q.size());
            fail_count++;
            angle_q.delete();
        end
    endtask

    // one apb transfer: setup cycle, access cycle, then an idle cycle
    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // program confirm_count and read it back
    task automatic write_confirm(input hsda_pkg::cnt_t value);
        logic [31:0] rd;
        apb_access(1'b1, ADDR_CONFIRM, {{(32-hsda_pkg::CNT_W){1'b0}}, value}, rd);
        trk_confirm = value;
        apb_access(1'b0, ADDR_CONFIRM, '0, rd);
        if (rd[hsda_pkg::CNT_W-1:0] != value)
        begin
            $error("confirm_count readback expected %0d actual %0d", value,
                   rd[hsda_pkg::CNT_W-1:0]);
            fail_count++;
        end
    endtask

    // result side: compare accepted beats and drive ready, including the
    // long hold-off that lets the block fill and stall its input
    initial
    begin : result_sink
        angle_beat_t want;
        int          hold_left;
        int          hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (angle_q.size() == 0)
                begin
                    $error("result beat with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    want = angle_q.pop_front();
                    if (res_ch.rotor_angle !== want.angle)
                    begin
                        $error("rotor_angle expected %0d actual %0d",
                               want.angle, res_ch.rotor_angle);
                        fail_count++;
                    end
                    if (res_ch.step_direction !== want.step)
                    begin
                        $error("step_direction expected %0d actual %0d",
                               want.step, res_ch.step_direction);
                        fail_count++;
                    end
                    if (res_ch.accepted_sector !== want.sector)
                    begin
                        $error("accepted_sector expected %0d actual %0d",
                               want.sector, res_ch.accepted_sector);
                        fail_count++;
                    end
                end
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        int             sent;
        int             kind;
        int             step;
        int             rot;
        int             len;
        int             tgt;
        logic [2:0]     pat;
        hsda_pkg::cnt_t seg_confirm;

        // every input known from time zero
        rst_n          = 1'b0;
        hall_ch.valid  = 1'b0;
        hall_ch.hall_a = 1'b0;
        hall_ch.hall_b = 1'b0;
        hall_ch.hall_c = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        fail_count     = 0;
        hold_req       = 0;
        send_idle_pct  = 27;
        recv_idle_pct  = 78;

        // tracker matches the block after reset
        trk_raw     = '0;
        trk_prev    = '0;
        trk_cur     = '0;
        trk_ref     = '0;
        trk_cnt     = '0;
        trk_confirm = hsda_pkg::CONFIRM_RESET;
        trk_seeded  = 1'b0;
        trk_acc     = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening table, run at the reset confirm_count
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_sample(DIRECTED_ROWS[i].pat, DIRECTED_ROWS[i].typed,
                        DIRECTED_ROWS[i].want);

        // random rotation traffic in phases; the block is empty at each
        // register write since every sample yields exactly one beat
        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            drain_results();
            case (seg)
                0:       seg_confirm = 4'd1;
                1:       seg_confirm = 4'd15;
                2:       seg_confirm = 4'd0;
                3:       seg_confirm = hsda_pkg::cnt_t'($urandom_range(14, 1));
                4:       seg_confirm = 4'd2;
                default: seg_confirm = hsda_pkg::cnt_t'($urandom_range(15, 0));
            endcase
            write_confirm(seg_confirm);

            // sender sparse / receiver busy, then swapped, then full rate
            if (seg < 2)
            begin
                send_idle_pct = 27;
                recv_idle_pct <= 78;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 78;
                recv_idle_pct <= 27;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            // long receiver stall while the sender keeps offering
            if (seg == 4)
                hold_req <= hold_req + 1;

            rot  = $urandom_range(1) ? 1 : -1;
            sent = 0;
            while (sent < SEG_ITEMS)
            begin
                kind = $urandom_range(99);
                if (kind < 12)
                begin
                    // single noise sample, any line pattern
                    pat = 3'($urandom_range(7));
                    send_sample(pat, 1'b0, '0);
                    sent++;
                end
                else
                begin
                    // a run of one sector: mostly a neighbor in the current
                    // rotation sense, sometimes a jump
                    if ($urandom_range(9) == 0)
                        rot = -rot;
                    if (kind < 26)
                        step = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(4, 2));
                    else
                        step = rot;
                    tgt = ((int'(trk_cur) + step) % NUM_SECTORS + NUM_SECTORS) % NUM_SECTORS;
                    len = int'(trk_confirm) + 1 + int'($urandom_range(2));
                    // broken run, too short to confirm
                    if ($urandom_range(9) == 0)
                        len = int'($urandom_range((trk_confirm > 1) ? trk_confirm : 1, 1));
                    for (int i = 0; i < len; i++)
                    begin
                        pat = SECTOR_PAT[tgt];
                        // all-low or all-high inside a run keeps the raw sector
                        if (i > 0 && $urandom_range(15) == 0)
                            pat = $urandom_range(1) ? hsda_pkg::PAT_ALL_LOW : PAT_ALL_HIGH;
                        send_sample(pat, 1'b0, '0);
                        sent++;
                    end
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
